// ----- design/mlfq_pkg.sv -----
// Shared types and constants for the multilevel feedback queue scheduler.
// Used by the controller, the datapath, the top level and the checker.
package mlfq_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int PID_BITS   = 16;
    localparam int LEVELS     = 3;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int LVL_W      = 2;
    localparam int Q_W        = 2;
    localparam int CMP_W      = (PID_BITS > 16) ? PID_BITS : 16;
    localparam int CFG_ADDR_W = 4;

    localparam logic [LVL_W-1:0] LVL_TOP    = 2'd1;
    localparam logic [LVL_W-1:0] LVL_MID    = 2'd2;
    localparam logic [LVL_W-1:0] LVL_BOTTOM = 2'd3;
    localparam logic [7:0]       TICK_MAX   = 8'hFF;

    localparam logic [1:0] REG_SLICE_L1 = 2'd0;
    localparam logic [1:0] REG_SLICE_L2 = 2'd1;
    localparam logic [1:0] REG_SLICE_L3 = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_EXIT   = 2'd2,
        CMD_KILL   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_READY   = 2'd1,
        ST_EXEC    = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_KILL,
        S_DISPATCH,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] target_pid;
        logic [7:0]  kill_signal;
    } t_in_beat;

    typedef struct packed {
        logic        running;
        logic [2:0]  running_slot;
        logic [15:0] running_pid;
        logic        switched;
        logic [15:0] new_pid;
        logic        create_ok;
    } t_out_beat;

    typedef struct packed {
        logic capture;
        logic tick;
        logic create;
        logic exit_free;
        logic kill_step;
        logic dispatch;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic run_valid;
        logic expire;
        logic kill_done;
        logic out_full;
    } t_dp_stat;

    // Level 1..3 maps to queue 0..2.
    function automatic logic [Q_W-1:0] level_to_queue(input logic [LVL_W-1:0] lvl);
        level_to_queue = Q_W'(lvl - LVL_TOP);
    endfunction

endpackage

// ----- design/mlfq_process_scheduler.sv -----
// Top level of the multilevel feedback queue process scheduler.
// Depends on mlfq_pkg, mlfq_ctrl and mlfq_dp; holds the slice registers.
//
// The scheduler keeps a table of SLOT_COUNT process slots and three FIFO ready
// queues, one per priority level, and handles one command per input beat: a tick
// or yield charges the runner and demotes and requeues it when its slice is used
// up, a create claims the lowest free slot at level one with a fresh pid, an exit
// frees the runner and dispatches the next one, and a kill frees one pid when its
// signal is zero or one or, for pid zero, every slot but slot zero. Each command
// gives exactly one result beat. Input beats are taken one at a time: the input
// stalls from acceptance until the result beat is loaded into the output
// register. The kill sequencer visits one slot per cycle and removes a freed
// slot from its queue in that same cycle. A result beat waits in the output
// register while the next input beat is taken; when the consumer stalls, the
// block holds its finished step until that register frees up. The slice
// registers sit at byte addresses 0, 4 and 8 and keep only the low byte of a
// write; they should be changed only while the block is idle.
module mlfq_process_scheduler
    import mlfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [LEVELS-1:0][7:0] r_slice;
    logic [1:0]             reg_idx;
    logic                   cfg_wr;
    t_dp_cmd                dp_cmd;
    t_dp_stat               dp_stat;

    // The register index is the word address; byte lanes are ignored.
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice[0] <= 8'd1;
            r_slice[1] <= 8'd2;
            r_slice[2] <= 8'd4;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SLICE_L1: r_slice[0] <= pwdata[7:0];
                REG_SLICE_L2: r_slice[1] <= pwdata[7:0];
                REG_SLICE_L3: r_slice[2] <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SLICE_L1: prdata = {24'd0, r_slice[0]};
            REG_SLICE_L2: prdata = {24'd0, r_slice[1]};
            REG_SLICE_L3: prdata = {24'd0, r_slice[2]};
            default:      prdata = 32'd0;
        endcase
    end

    // The controller sequences each command; the datapath owns all scheduler state.
    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    mlfq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_data   (i_in_data),
        .i_slice     (r_slice),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- design/mlfq_ctrl.sv -----
// Sequencing state machine of the scheduler.
// Depends on mlfq_pkg; drives the datapath through t_dp_cmd.
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_RUN;
                end
            end
            S_RUN: begin
                case (i_stat.cmd)
                    CMD_TICK: begin
                        if (!i_stat.run_valid) begin
                            n_state = S_DISPATCH;
                        end else begin
                            o_cmd.tick = 1'b1;
                            n_state    = i_stat.expire ? S_DISPATCH : S_RESULT;
                        end
                    end
                    CMD_CREATE: begin
                        o_cmd.create = 1'b1;
                        n_state      = S_RESULT;
                    end
                    CMD_EXIT: begin
                        o_cmd.exit_free = 1'b1;
                        n_state         = S_DISPATCH;
                    end
                    default: begin
                        n_state = S_KILL;
                    end
                endcase
            end
            S_KILL: begin
                o_cmd.kill_step = 1'b1;
                if (i_stat.kill_done) begin
                    n_state = S_RESULT;
                end
            end
            S_DISPATCH: begin
                o_cmd.dispatch = 1'b1;
                n_state        = S_RESULT;
            end
            S_RESULT: begin
                if (!i_stat.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- design/mlfq_dp.sv -----
// Slot table, three ready queues, run state and output register of the scheduler.
// Depends on mlfq_pkg; commanded by mlfq_ctrl.
module mlfq_dp
    import mlfq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  t_in_beat               i_in_data,
    input  logic [LEVELS-1:0][7:0] i_slice,
    input  logic                   i_out_stall,
    output t_dp_stat               o_stat,
    output logic                   o_out_valid,
    output t_out_beat              o_out_data
);

    t_slot_st            r_status [SLOT_COUNT];
    t_slot_st            n_status [SLOT_COUNT];
    logic [PID_BITS-1:0] r_pid    [SLOT_COUNT];
    logic [PID_BITS-1:0] n_pid    [SLOT_COUNT];
    logic [LVL_W-1:0]    r_level  [SLOT_COUNT];
    logic [LVL_W-1:0]    n_level  [SLOT_COUNT];
    logic [SLOT_W-1:0]   r_q_ent  [LEVELS][SLOT_COUNT];
    logic [SLOT_W-1:0]   n_q_ent  [LEVELS][SLOT_COUNT];
    logic [CNT_W-1:0]    r_q_cnt  [LEVELS];
    logic [CNT_W-1:0]    n_q_cnt  [LEVELS];

    logic [SLOT_W-1:0]   r_run_idx, n_run_idx;
    logic                r_run_valid, n_run_valid;
    logic [7:0]          r_ticks, n_ticks;
    logic [PID_BITS-1:0] r_pid_ctr, n_pid_ctr;
    t_cmd                r_cmd, n_cmd;
    logic [15:0]         r_tpid, n_tpid;
    logic [7:0]          r_sig, n_sig;
    logic                r_prev_valid, n_prev_valid;
    logic [SLOT_W-1:0]   r_prev_idx, n_prev_idx;
    logic [SLOT_W-1:0]   r_kill_idx, n_kill_idx;
    logic [15:0]         r_new_pid, n_new_pid;
    logic                r_create_ok, n_create_ok;
    t_out_beat           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [SLOT_W-1:0]   sel_idx;
    t_slot_st            sel_status;
    logic [PID_BITS-1:0] sel_pid;
    logic [LVL_W-1:0]    sel_level;
    logic [7:0]          slice_sel;
    logic [7:0]          ticks_inc;
    logic                expire;
    logic [LVL_W-1:0]    lvl_up;
    logic                kill_hit;
    logic                free_en;
    logic                free_rm;
    logic [Q_W-1:0]      free_q;
    logic                push_en;
    logic [Q_W-1:0]      push_q;
    logic [SLOT_W-1:0]   push_slot;
    logic                cr_found;
    logic [SLOT_W-1:0]   cr_idx;
    logic                pop_en;
    logic [Q_W-1:0]      pop_q;
    logic [SLOT_W-1:0]   pop_slot;
    logic                hit_seen;

    // One slot is looked at per cycle: the kill cursor while killing, else the runner.
    assign sel_idx    = i_cmd.kill_step ? r_kill_idx : r_run_idx;
    assign sel_status = r_status[sel_idx];
    assign sel_pid    = r_pid[sel_idx];
    assign sel_level  = r_level[sel_idx];

    always_comb begin
        case (sel_level)
            LVL_MID:    slice_sel = i_slice[1];
            LVL_BOTTOM: slice_sel = i_slice[2];
            default:    slice_sel = i_slice[0];
        endcase
    end

    assign ticks_inc = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 8'd1;
    assign expire    = (ticks_inc >= slice_sel);
    assign lvl_up    = (sel_level == LVL_BOTTOM) ? LVL_BOTTOM : sel_level + LVL_W'(1);

    assign kill_hit = (r_tpid == 16'd0) ||
                      ((r_sig <= 8'd1) && (sel_status != ST_INVALID) &&
                       (CMP_W'(sel_pid) == CMP_W'(r_tpid)));
    assign free_en  = (i_cmd.exit_free && r_run_valid) || (i_cmd.kill_step && kill_hit);
    assign free_rm  = (sel_status == ST_READY);
    assign free_q   = level_to_queue(sel_level);

    // Lowest invalid slot for a create.
    always_comb begin
        cr_found = 1'b0;
        cr_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_status[i] == ST_INVALID) begin
                cr_found = 1'b1;
                cr_idx   = SLOT_W'(i);
            end
        end
    end

    // Highest-priority non-empty queue (lowest index, level one first) for a dispatch.
    always_comb begin
        pop_en   = 1'b0;
        pop_q    = '0;
        pop_slot = '0;
        for (int q = LEVELS - 1; q >= 0; q--) begin
            if (r_q_cnt[q] != '0) begin
                pop_en   = i_cmd.dispatch;
                pop_q    = Q_W'(q);
                pop_slot = r_q_ent[q][0];
            end
        end
    end

    always_comb begin
        push_en   = 1'b0;
        push_q    = '0;
        push_slot = r_run_idx;
        if (i_cmd.tick && expire) begin
            push_en = 1'b1;
            push_q  = level_to_queue(lvl_up);
        end else if (i_cmd.create && cr_found) begin
            push_en   = 1'b1;
            push_q    = level_to_queue(LVL_TOP);
            push_slot = cr_idx;
        end
    end

    always_comb begin
        n_status     = r_status;
        n_pid        = r_pid;
        n_level      = r_level;
        n_q_ent      = r_q_ent;
        n_q_cnt      = r_q_cnt;
        n_run_idx    = r_run_idx;
        n_run_valid  = r_run_valid;
        n_ticks      = r_ticks;
        n_pid_ctr    = r_pid_ctr;
        n_cmd        = r_cmd;
        n_tpid       = r_tpid;
        n_sig        = r_sig;
        n_prev_valid = r_prev_valid;
        n_prev_idx   = r_prev_idx;
        n_kill_idx   = r_kill_idx;
        n_new_pid    = r_new_pid;
        n_create_ok  = r_create_ok;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        hit_seen     = 1'b0;

        if (i_cmd.capture) begin
            n_cmd        = t_cmd'(i_in_data.cmd);
            n_tpid       = i_in_data.target_pid;
            n_sig        = i_in_data.kill_signal;
            n_prev_valid = r_run_valid;
            n_prev_idx   = r_run_idx;
            n_new_pid    = '0;
            n_create_ok  = 1'b0;
            // A kill of pid zero spares slot zero, so its sweep starts at slot one.
            n_kill_idx   = (i_in_data.target_pid == 16'd0) ? SLOT_W'(1) : '0;
        end

        if (i_cmd.tick) begin
            n_ticks = ticks_inc;
            if (expire) begin
                n_level[r_run_idx]  = lvl_up;
                n_status[r_run_idx] = ST_READY;
                n_run_valid         = 1'b0;
            end
        end

        if (i_cmd.create && cr_found) begin
            n_pid[cr_idx]    = r_pid_ctr;
            n_status[cr_idx] = ST_READY;
            n_level[cr_idx]  = LVL_TOP;
            n_pid_ctr        = r_pid_ctr + PID_BITS'(1);
            n_new_pid        = 16'(r_pid_ctr);
            n_create_ok      = 1'b1;
        end

        if (free_en) begin
            n_status[sel_idx] = ST_INVALID;
            n_pid[sel_idx]    = '0;
            n_level[sel_idx]  = LVL_TOP;
            if (r_run_valid && (r_run_idx == sel_idx)) begin
                n_run_valid = 1'b0;
            end
        end

        if (i_cmd.kill_step) begin
            n_kill_idx = r_kill_idx + SLOT_W'(1);
        end

        if (pop_en) begin
            n_status[pop_slot] = ST_EXEC;
            n_run_idx          = pop_slot;
            n_run_valid        = 1'b1;
            n_ticks            = '0;
        end

        for (int q = 0; q < LEVELS; q++) begin
            if (push_en && (push_q == Q_W'(q)) && (r_q_cnt[q] < CNT_W'(SLOT_COUNT))) begin
                n_q_ent[q][r_q_cnt[q][SLOT_W-1:0]] = push_slot;
                n_q_cnt[q] = r_q_cnt[q] + CNT_W'(1);
            end
            if (free_en && free_rm && (free_q == Q_W'(q))) begin
                // Close the gap left by the removed slot; entries ahead of it stay in place.
                hit_seen = 1'b0;
                for (int j = 0; j < SLOT_COUNT; j++) begin
                    if ((CNT_W'(j) < r_q_cnt[q]) && (r_q_ent[q][j] == sel_idx)) begin
                        hit_seen = 1'b1;
                    end
                    if (hit_seen && (j + 1 < SLOT_COUNT)) begin
                        n_q_ent[q][j] = r_q_ent[q][j+1];
                    end
                end
                if (hit_seen) begin
                    n_q_cnt[q] = r_q_cnt[q] - CNT_W'(1);
                end
            end
            if (pop_en && (pop_q == Q_W'(q))) begin
                for (int j = 0; j + 1 < SLOT_COUNT; j++) begin
                    n_q_ent[q][j] = r_q_ent[q][j+1];
                end
                n_q_cnt[q] = r_q_cnt[q] - CNT_W'(1);
            end
        end

        if (i_cmd.load_out) begin
            n_out.running      = r_run_valid;
            n_out.running_slot = r_run_valid ? 3'(r_run_idx) : 3'd0;
            n_out.running_pid  = r_run_valid ? 16'(sel_pid) : 16'd0;
            n_out.switched     = r_run_valid && (!r_prev_valid || (r_run_idx != r_prev_idx));
            n_out.new_pid      = r_new_pid;
            n_out.create_ok    = r_create_ok;
            n_out_valid        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_status[i] <= ST_INVALID;
                r_pid[i]    <= '0;
                r_level[i]  <= LVL_TOP;
            end
            r_status[0] <= ST_EXEC;
            r_pid[0]    <= PID_BITS'(1);
            for (int q = 0; q < LEVELS; q++) begin
                r_q_cnt[q] <= '0;
            end
            r_run_idx   <= '0;
            r_run_valid <= 1'b1;
            r_ticks     <= '0;
            r_pid_ctr   <= PID_BITS'(2);
            r_out_valid <= 1'b0;
        end else begin
            r_status    <= n_status;
            r_pid       <= n_pid;
            r_level     <= n_level;
            r_q_cnt     <= n_q_cnt;
            r_run_idx   <= n_run_idx;
            r_run_valid <= n_run_valid;
            r_ticks     <= n_ticks;
            r_pid_ctr   <= n_pid_ctr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_ent      <= n_q_ent;
        r_cmd        <= n_cmd;
        r_tpid       <= n_tpid;
        r_sig        <= n_sig;
        r_prev_valid <= n_prev_valid;
        r_prev_idx   <= n_prev_idx;
        r_kill_idx   <= n_kill_idx;
        r_new_pid    <= n_new_pid;
        r_create_ok  <= n_create_ok;
        r_out        <= n_out;
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.run_valid = r_run_valid;
    assign o_stat.expire    = expire;
    assign o_stat.kill_done = (r_kill_idx == SLOT_W'(SLOT_COUNT - 1));
    assign o_stat.out_full  = r_out_valid && i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule

// ----- design/mlfq_checker.sv -----
// Port-level checks for the scheduler, bound to its top level.
// Depends on mlfq_pkg and mlfq_process_scheduler.
module mlfq_checker
    import mlfq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_beat              i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_beat             o_out_data,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [31:0]           pwdata,
    input logic [31:0]           prdata,
    input logic                  pready
);

    // An idle result carries no slot and no pid.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.running) |->
            (o_out_data.running_slot == 3'd0 && o_out_data.running_pid == 16'd0))
        else $error("idle result carries a slot or pid");

    // A switch always lands on a running process.
    a_switch_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.switched) |-> o_out_data.running)
        else $error("switch reported with nothing running");

    // Only a successful create hands out a pid.
    a_new_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.create_ok) |-> (o_out_data.new_pid == 16'd0))
        else $error("new pid without a create");

    // An accepted beat keeps the block busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after acceptance");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

endmodule

bind mlfq_process_scheduler mlfq_checker u_mlfq_checker (.*);
